@@ src/signed_integer_to_radix_digits_assert.svh @@
// Assertion macros for the radix digit converter.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// plain property, sampled on clock, off during reset
`define SIRTD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sirtd assertion failed");

// same-cycle implication
`define SIRTD_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sirtd implication failed");

// next-cycle implication
`define SIRTD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sirtd next-cycle implication failed");

`else

`define SIRTD_ASSERT(label, prop)
`define SIRTD_ASSERT_IMPLIES(label, ante, cons)
`define SIRTD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/sirtd_pkg.sv @@
// Shared constants, types and helpers of the radix digit converter.
`default_nettype none

package sirtd_pkg;

   localparam int MAX_BASE_DEFAULT   = 16;
   localparam int VALUE_BITS_DEFAULT = 32;

   // quotient bits retired per divider cycle
   localparam int STEP_BITS = 4;

   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT_COUNT = 2'd2;

   localparam logic [63:0] ALPHA_LOW_RESET  = 64'd3978425819141910832;
   localparam logic [63:0] ALPHA_HIGH_RESET = 64'd7378413942531504440;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;

   typedef logic [7:0] char_type;

   localparam char_type CHAR_NUL   = 8'h00;
   localparam char_type CHAR_TAB   = 8'h09;
   localparam char_type CHAR_CR    = 8'h0D;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_PLUS  = 8'h2B;
   localparam char_type CHAR_MINUS = 8'h2D;

   // characters that may not serve as digits
   function automatic logic char_forbidden(input char_type c);
      logic bad;
      bad = (c == CHAR_NUL) || (c == CHAR_SPACE) || (c == CHAR_PLUS) ||
            (c == CHAR_MINUS) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      return bad;
   endfunction

endpackage

`default_nettype wire

@@ src/sirtd_divider.sv @@
// Iterative divider: unsigned value by a small base, four quotient bits per cycle.
`default_nettype none

module sirtd_divider
   import sirtd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int DIGIT_W    = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [DIGIT_W:0]      base,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [DIGIT_W-1:0]         remainder
);

   localparam int STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_W  = STEPS * STEP_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  q_ff, q_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;

   logic [DIGIT_W-1:0]   r_next;
   logic [STEP_BITS-1:0] q_bits;

   // one restoring step per quotient bit, narrow remainder
   always_comb begin
      logic [DIGIT_W:0] t;
      r_next = rem_ff;
      q_bits = '0;
      for (int b = 0; b < STEP_BITS; b++) begin
         t = {r_next, q_ff[DIV_W-1-b]};
         if (t >= base) begin
            t = t - base;
            q_bits[STEP_BITS-1-b] = 1'b1;
         end
         r_next = t[DIGIT_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         q_in    = DIV_W'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIV_W-STEP_BITS-1:0], q_bits};
         rem_in = r_next;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ src/sirtd_digit_stack.sv @@
// Digit stack memory: one write port, one registered read port.
`default_nettype none

module sirtd_digit_stack
   import sirtd_pkg::*;
#(
   parameter int DEPTH = VALUE_BITS_DEFAULT,
   parameter int WIDTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/signed_integer_to_radix_digits.sv @@
// Top level: signed integer to text in a configurable radix.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  req     | in  | req_valid / req_stall | req_value
//  rsp     | out | rsp_valid / rsp_stall | rsp_character, rsp_invalid_alphabet,
//          |     |                       | rsp_last
//  csr     | in  | csr_valid / csr_ready | csr_index, csr_data
//
// Steps: accept, then the alphabet check (one digit character per cycle),
//   then one divider run per digit (4-bit-per-cycle divider), then a minus sign
//   for a negative value, then a stack read and an output load per emitted digit.
// One item at a time: req_stall is high from accept until the last beat is loaded.
// Reset (synchronous) restores alphabet "0123456789abcdef" and base 10.
// rsp_stall holds the output register; the sequencer waits there.
`default_nettype none
`include "signed_integer_to_radix_digits_assert.svh"

module signed_integer_to_radix_digits
   import sirtd_pkg::*;
#(
   parameter int MAX_BASE   = MAX_BASE_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input item
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [31:0]     req_value,
   // result beats
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_invalid_alphabet,
   output logic                        rsp_last,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   localparam int DIGIT_W     = $clog2(MAX_BASE);
   localparam int ALPHA_DEPTH = 2 ** DIGIT_W;
   localparam int TOTAL_W     = $clog2(VALUE_BITS + 1);
   localparam int ADDR_W      = $clog2(VALUE_BITS);

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CHECK   = 3'd1;
   localparam logic [2:0] ST_DIV     = 3'd2;
   localparam logic [2:0] ST_SIGN    = 3'd3;
   localparam logic [2:0] ST_READ    = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;
   localparam logic [2:0] ST_INVALID = 3'd6;

   // configuration
   logic [63:0]        alpha_low_ff, alpha_low_in;
   logic [63:0]        alpha_high_ff, alpha_high_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // sequencer
   logic [2:0]            state_ff, state_in;
   logic [DIGIT_W-1:0]    idx_ff, idx_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   char_type rsp_char_ff, rsp_char_in;
   logic     rsp_inv_ff, rsp_inv_in;
   logic     rsp_last_ff, rsp_last_in;

   // divider and stack hookup
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [DIGIT_W-1:0]    div_remainder;
   logic                  st_wr;
   logic                  st_rd;
   logic [DIGIT_W-1:0]    st_rd_data;

   logic [VALUE_BITS-1:0] raw;
   logic [127:0]          alpha_all;
   char_type              alpha [ALPHA_DEPTH];
   logic                  char_bad;
   logic                  out_free;

   assign alpha_all = {alpha_high_ff, alpha_low_ff};

   for (genvar k = 0; k < ALPHA_DEPTH; k++) begin : g_alpha
      assign alpha[k] = alpha_all[k*8 +: 8];
   end

   // current digit character: forbidden byte, or repeated later in the alphabet
   always_comb begin
      char_bad = char_forbidden(alpha[idx_ff]);
      for (int j = 0; j < ALPHA_DEPTH; j++) begin
         if ((j > int'(idx_ff)) && (j < int'(count_ff)) && (alpha[j] == alpha[idx_ff])) begin
            char_bad = 1'b1;
         end
      end
   end

   assign raw          = req_value[VALUE_BITS-1:0];
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign div_dividend = (state_ff == ST_DIV) ? div_quotient : mag_ff;

   // configuration writes, only while idle
   always_comb begin
      alpha_low_in  = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      count_in      = count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALPHA_LOW:   alpha_low_in  = csr_data;
            CSR_ALPHA_HIGH:  alpha_high_in = csr_data;
            CSR_DIGIT_COUNT: count_in      = csr_data[COUNT_W-1:0];
            default:         ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      total_in     = total_ff;
      div_start    = 1'b0;
      st_wr        = 1'b0;
      st_rd        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_inv_in   = rsp_inv_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = raw[VALUE_BITS-1];
               mag_in = raw[VALUE_BITS-1] ? ({VALUE_BITS{1'b0}} - raw) : raw;
               idx_in = '0;
               if ((count_ff < COUNT_W'(2)) || (count_ff > COUNT_W'(MAX_BASE))) begin
                  state_in = ST_INVALID;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (char_bad) begin
               state_in = ST_INVALID;
            end else if (COUNT_W'(idx_ff) == (count_ff - COUNT_W'(1))) begin
               div_start = 1'b1;
               total_in  = '0;
               state_in  = ST_DIV;
            end else begin
               idx_in = idx_ff + DIGIT_W'(1);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               st_wr    = 1'b1;
               total_in = total_ff + TOTAL_W'(1);
               if (div_quotient == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_inv_in   = 1'b0;
               rsp_last_in  = 1'b0;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            // pop most significant remaining digit
            st_rd    = 1'b1;
            total_in = total_ff - TOTAL_W'(1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = alpha[st_rd_data];
               rsp_inv_in   = 1'b0;
               rsp_last_in  = (total_ff == '0);
               state_in     = (total_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         ST_INVALID: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_NUL;
               rsp_inv_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= ALPHA_LOW_RESET;
         alpha_high_ff <= ALPHA_HIGH_RESET;
         count_ff      <= COUNT_RESET;
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         mag_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         alpha_low_ff  <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
         count_ff      <= count_in;
         state_ff      <= state_in;
         total_ff      <= total_in;
         mag_ff        <= mag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_inv_ff  <= rsp_inv_in;
      rsp_last_ff <= rsp_last_in;
   end

   sirtd_divider #(
      .VALUE_BITS (VALUE_BITS),
      .DIGIT_W    (DIGIT_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .base      ((DIGIT_W+1)'(count_ff)),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   sirtd_digit_stack #(
      .DEPTH (VALUE_BITS),
      .WIDTH (DIGIT_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (total_ff[ADDR_W-1:0]),
      .wr_data (div_remainder),
      .rd_en   (st_rd),
      .rd_addr (ADDR_W'(total_ff - TOTAL_W'(1))),
      .rd_data (st_rd_data)
   );

   assign req_stall            = (state_ff != ST_IDLE);
   assign csr_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_character        = rsp_char_ff;
   assign rsp_invalid_alphabet = rsp_inv_ff;
   assign rsp_last             = rsp_last_ff;

   // an accepted item blocks the input on the next cycle
   `SIRTD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // the rejection beat is always the only one
   `SIRTD_ASSERT_IMPLIES(a_invalid_is_last, rsp_valid && rsp_invalid_alphabet, rsp_last)
   // never pop an empty stack
   `SIRTD_ASSERT_IMPLIES(a_pop_nonempty, state_ff == ST_READ, total_ff != '0)
   // divider results arrive only while the sequencer waits for them
   `SIRTD_ASSERT_IMPLIES(a_div_done_in_div, div_done, state_ff == ST_DIV)

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the signed integer to radix text converter.
`timescale 1ns / 100ps

module tb
   import sirtd_pkg::*;
;

   // one result beat: a character plus its flags
   typedef struct packed {
      char_type character;
      logic     invalid;
      logic     last;
   } text_beat_type;

   localparam longint unsigned RUN_LIMIT_NS = 64'd60_000_000;

   // ------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [31:0]     req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_character;
   logic                   rsp_invalid_alphabet;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   signed_integer_to_radix_digits uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_character        (rsp_character),
      .rsp_invalid_alphabet (rsp_invalid_alphabet),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the registers and the expected text queue
   // ------------------------------------------------------------------
   logic [127:0] shadow_alphabet = {ALPHA_HIGH_RESET, ALPHA_LOW_RESET};
   logic [4:0]   shadow_count    = COUNT_RESET;

   text_beat_type pending_text[$];

   int unsigned  values_sent   = 0;
   int unsigned  beats_checked = 0;
   int unsigned  reject_beats  = 0;
   int unsigned  reg_writes    = 0;
   int unsigned  fail_count    = 0;

   bit           quiet_mode = 1'b0;   // no new gaps on either side while set
   int           stall_left = 0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic char_type digit_char(input int unsigned d);
      return shadow_alphabet[8*d +: 8];
   endfunction

   // whitespace, sign characters and NUL may not stand as digits
   function automatic bit char_is_reserved(input char_type c);
      return (c == CHAR_NUL) || (c == CHAR_SPACE) || (c == CHAR_PLUS) ||
             (c == CHAR_MINUS) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic bit alphabet_accepted();
      int unsigned n;
      n = shadow_count;
      if (n < 2 || n > MAX_BASE_DEFAULT)
         return 1'b0;
      for (int i = 0; i < n; i++) begin
         if (char_is_reserved(digit_char(i)))
            return 1'b0;
         for (int j = i + 1; j < n; j++)
            if (digit_char(j) == digit_char(i))
               return 1'b0;
      end
      return 1'b1;
   endfunction

   // queue the text that one accepted value must produce
   function automatic void format_value(input logic [31:0] v);
      logic [31:0]   mag;
      int unsigned   base;
      int unsigned   digits[32];
      int            n;
      text_beat_type b;
      if (!alphabet_accepted()) begin
         b = '{character: CHAR_NUL, invalid: 1'b1, last: 1'b1};
         pending_text.push_back(b);
         return;
      end
      base = shadow_count;
      // two's complement negate keeps the most negative value exact
      mag = v[31] ? (32'd0 - v) : v;
      n = 0;
      do begin
         digits[n] = mag % base;
         mag = mag / base;
         n++;
      end while (mag != 0 && n < 32);
      if (v[31]) begin
         b = '{character: CHAR_MINUS, invalid: 1'b0, last: 1'b0};
         pending_text.push_back(b);
      end
      for (int i = n - 1; i >= 0; i--) begin
         b = '{character: digit_char(digits[i]), invalid: 1'b0, last: (i == 0)};
         pending_text.push_back(b);
      end
   endfunction

   // ------------------------------------------------------------------
   // Result checker: each accepted beat against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      text_beat_type got, want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{character: rsp_character, invalid: rsp_invalid_alphabet,
                 last: rsp_last};
         beats_checked++;
         if (got.invalid)
            reject_beats++;
         if (pending_text.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected beat char=%02h invalid=%0b last=%0b",
                     $time, got.character, got.invalid, got.last);
         end else begin
            want = pending_text.pop_front();
            if (got !== want) begin
               fail_count++;
               $display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b (char/invalid/last)",
                        $time, want.character, want.invalid, want.last,
                        got.character, got.invalid, got.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure: mostly short stalls, now and then a long one
   // ------------------------------------------------------------------
   function automatic int stall_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 93)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
         stall_left = stall_length() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // sender idle gap before a beat
   function automatic int send_gap();
      int r;
      if (quiet_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // Channel tasks
   // ------------------------------------------------------------------
   // Valid stays high between back-to-back beats; it is lowered only when a
   // gap follows, so no step sees two assignments to it.
   task automatic send_value(input logic [31:0] v);
      int gap;
      gap = send_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= $urandom;   // junk while idle
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall !== 1'b0);
      format_value(v);
      values_sent++;
   endtask

   // drop valid and hold off until every expected beat has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_text.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ALPHA_LOW:   shadow_alphabet[63:0]   = data;
         CSR_ALPHA_HIGH:  shadow_alphabet[127:64] = data;
         CSR_DIGIT_COUNT: shadow_count            = data[4:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // full register set; junk above the count field must be dropped
   task automatic load_alphabet(input logic [127:0] a, input logic [4:0] n);
      write_reg(CSR_ALPHA_LOW, a[63:0]);
      write_reg(CSR_ALPHA_HIGH, a[127:64]);
      write_reg(CSR_DIGIT_COUNT, {$urandom, 27'($urandom), n});
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic char_type reserved_char();
      case ($urandom_range(0, 4))
         0: return CHAR_NUL;
         1: return CHAR_SPACE;
         2: return CHAR_TAB + char_type'($urandom_range(0, 4));
         3: return CHAR_PLUS;
         default: return CHAR_MINUS;
      endcase
   endfunction

   // n distinct legal digits, random bytes in the unused slots
   function automatic logic [127:0] random_alphabet(input int n);
      logic [127:0] a;
      char_type     c;
      bit           taken[256];
      a = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < n && i < 16; i++) begin
         do c = char_type'($urandom_range(0, 255));
         while (char_is_reserved(c) || taken[c]);
         taken[c] = 1'b1;
         a[8*i +: 8] = c;
      end
      return a;
   endfunction

   function automatic logic [31:0] random_value(input int base);
      int           r;
      logic [63:0]  p;
      logic [31:0]  v;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         v = $urandom;
      end else if (r < 55) begin
         v = $urandom_range(0, 300);
         if ($urandom_range(0, 1)) v = -v;
      end else if (r < 70) begin
         case ($urandom_range(0, 5))
            0: v = 32'h0000_0000;
            1: v = 32'h0000_0001;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h7FFF_FFFF;
            4: v = 32'h8000_0000;
            default: v = 32'h8000_0001;
         endcase
      end else if (r < 85 && base >= 2 && base <= 16) begin
         // digit-count boundaries: powers of the base and their neighbors
         p = 1;
         repeat ($urandom_range(0, 31))
            if (p * base < 64'h1_0000_0000) p = p * base;
         v = p[31:0] + $urandom_range(0, 2) - 1;
         if ($urandom_range(0, 1)) v = -v;
      end else begin
         v = $urandom >> $urandom_range(0, 31);
         if ($urandom_range(0, 1)) v = -v;
      end
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // decimal out of reset: zero, signs, the extremes
   task automatic test_reset_defaults();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd123456789);
      send_value(32'hAAAA_AAAA);
      wait_drained();
   endtask

   // smallest and largest base, plus bytes past the count left unchecked
   task automatic test_base_extremes();
      logic [127:0] a;
      write_reg(CSR_DIGIT_COUNT, 64'd2);
      send_value(32'h8000_0000);   // longest text: sign and 32 digits
      send_value(32'h7FFF_FFFF);
      send_value(32'd0);
      wait_drained();
      write_reg(CSR_DIGIT_COUNT, 64'd16);
      send_value(32'hFFFF_FFFF);
      send_value(32'hFEDC_BA98);
      send_value(32'h0123_4567);
      wait_drained();
      // reserved and repeated bytes beyond the third digit do not matter
      a = {ALPHA_HIGH_RESET, ALPHA_LOW_RESET};
      a[8*3 +: 8] = CHAR_SPACE;
      a[8*4 +: 8] = CHAR_MINUS;
      a[8*5 +: 8] = a[7:0];
      load_alphabet(a, 5'd3);
      send_value(32'h8000_0000);
      wait_drained();
   endtask

   // every way an alphabet can be refused
   task automatic test_rejected_alphabets();
      logic [127:0] base_set;
      logic [127:0] a;
      char_type     bad[7];
      int           p, q;
      base_set = {ALPHA_HIGH_RESET, ALPHA_LOW_RESET};
      bad = '{CHAR_NUL, CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_PLUS, CHAR_MINUS,
              CHAR_TAB + 8'd2};
      foreach (bad[k]) begin
         a = base_set;
         p = $urandom_range(0, 15);
         a[8*p +: 8] = bad[k];
         load_alphabet(a, 5'd16);
         send_value($urandom);
         wait_drained();
      end
      // duplicate digit
      a = base_set;
      p = $urandom_range(1, 15);
      q = $urandom_range(0, p - 1);
      a[8*p +: 8] = a[8*q +: 8];
      load_alphabet(a, 5'd16);
      send_value($urandom);
      wait_drained();
      // counts outside 2..16
      load_alphabet(base_set, 5'd0);
      send_value(32'd7);
      wait_drained();
      write_reg(CSR_DIGIT_COUNT, 64'd1);
      send_value(32'h8000_0000);
      wait_drained();
      write_reg(CSR_DIGIT_COUNT, 64'd17);
      send_value(32'hFFFF_FFFF);
      wait_drained();
   endtask

   // random alphabets and counts, phase by phase, mostly legal settings
   task automatic test_random_settings();
      logic [127:0] a;
      int           kind, r, n, p, q, items;
      bit           refused;
      for (int phase = 0; phase < 21; phase++) begin
         r = $urandom_range(0, 99);
         n = (r < 20) ? 2 : (r < 40) ? 16 : $urandom_range(2, 16);
         a = random_alphabet(n);
         kind = $urandom_range(0, 99);
         refused = 1'b1;
         if (kind < 8) begin
            case ($urandom_range(0, 2))
               0: n = 0;
               1: n = 1;
               default: n = $urandom_range(17, 31);
            endcase
         end else if (kind < 14) begin
            p = $urandom_range(0, n - 1);
            a[8*p +: 8] = reserved_char();
         end else if (kind < 20) begin
            p = $urandom_range(1, n - 1);
            q = $urandom_range(0, p - 1);
            a[8*p +: 8] = a[8*q +: 8];
         end else begin
            refused = 1'b0;
         end
         quiet_mode = (phase % 5 == 3);
         load_alphabet(a, n[4:0]);
         items = refused ? 5 : 23;
         repeat (items) begin
            send_value(random_value(n));
            // occasional full pause until the converter has emptied
            if ($urandom_range(0, 99) < 3)
               wait_drained();
         end
         wait_drained();
      end
      quiet_mode = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_base_extremes();
      test_rejected_alphabets();
      test_random_settings();
      wait_drained();
      // a little more than one full base-2 conversion, to catch stray beats
      repeat (400) @(posedge clock);
      $display("Summary: %0d values converted, %0d beats checked (%0d refused-alphabet beats)",
               values_sent, beats_checked, reject_beats);
      $display("Summary: %0d register writes over bases 0..31, legal and refused alphabets",
               reg_writes);
      if (fail_count == 0 && pending_text.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout with %0d beats still expected", pending_text.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
